[rtl/pirt_pkg.sv]
package pirt_pkg;

	localparam int unsigned SEQ_W = 32;
	localparam int unsigned LEN_W = 31;
	localparam int unsigned PCOUNT_W = 7;

	// header command codes
	typedef enum logic [2:0] {
		CMD_SUBMIT_REQ = 3'd0,
		CMD_UNLINK_REQ = 3'd1,
		CMD_SUBMIT_RSP = 3'd2,
		CMD_UNLINK_RSP = 3'd3
	} cmd_t;

	// table action codes
	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_INSERTED = 2'd1,
		ACT_TAGGED   = 2'd2,
		ACT_REMOVED  = 2'd3
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		STS_OK         = 2'd0,
		STS_UNEXPECTED = 2'd1,
		STS_FULL       = 2'd2,
		STS_DUPLICATE  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]       command;
		logic [SEQ_W-1:0] seq_number;
		logic             direction_in;
		logic [LEN_W-1:0] transfer_length;
		logic [SEQ_W-1:0] unlink_target;
	} in_item_t;

	typedef struct packed {
		logic                restore_dir_in;
		logic [1:0]          action;
		logic [1:0]          status;
		logic [PCOUNT_W-1:0] pending_count;
	} out_item_t;

	// one table row as stored in memory
	typedef struct packed {
		logic             valid;
		logic [SEQ_W-1:0] key;
		logic [SEQ_W-1:0] tag;
	} entry_t;

endpackage

[rtl/pending_in_request_tracker.sv]
// Pending IN request tracker.
// Input channel in_valid/in_ready/in_data carries one header event per
// transaction; output channel out_valid/out_ready/out_data returns exactly
// one result per event, in order. cfg_wr_en/cfg_wr_data write client_mode
// (1 tracks, 0 passes everything) with no wait; reset value is 1.
// The table lives in one synchronous memory (valid, key, unlink tag per row)
// with one read and one write port. An event that touches the table scans
// every row through the read port, one row per cycle, then writes back at
// most one row. An event that leaves the table alone goes from acceptance
// straight to the finish state, where its result is registered once the
// output register is free.
// One event is worked on at a time; the scan of the read port paces tracked
// events.
// After reset a clearing pass over all TABLE_ENTRIES rows marks every row free;
// in_ready stays low during it, configuration writes are taken as ever.
// A finished result sits in the output register; the next event is accepted
// and scanned meanwhile, and only its write-back and result wait while the receiver
// stalls.
module pending_in_request_tracker
	import pirt_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t state_q;

	// table memory
	entry_t mem [TABLE_ENTRIES];

	logic             client_mode_q;
	in_item_t         item_q;
	logic             work_q;
	logic [SEQ_W-1:0] srch_key_q;
	logic [AW-1:0]    scan_addr_q;
	logic             issued_all_q;
	logic [CW-1:0]    count_q;

	entry_t        rd_entry_s1;
	logic [AW-1:0] rd_addr_s1;
	logic          rd_vld_s1;

	logic             key_hit_q;
	logic [AW-1:0]    key_idx_q;
	logic             free_hit_q;
	logic [AW-1:0]    free_idx_q;
	logic             tag_hit_q;
	logic [AW-1:0]    tag_idx_q;
	logic [SEQ_W-1:0] tag_key_q;

	logic          out_valid_q;
	out_item_t     out_q;

	logic          fire;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	logic          cnt_inc;
	logic          cnt_dec;
	logic          res_restore;
	action_t       res_action;
	status_t       res_status;
	logic          accept;
	logic          needs_scan;
	logic [SEQ_W-1:0] acc_key;
	logic [CW-1:0]    count_next;
	logic [CW+PCOUNT_W-1:0] count_ext;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign fire      = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			client_mode_q <= cfg_wr_data;
		end
	end

	// decide at acceptance whether the table must be searched
	always_comb begin
		needs_scan = 1'b0;
		acc_key    = in_data.seq_number;
		unique case (in_data.command)
			CMD_SUBMIT_REQ: begin
				needs_scan = (in_data.seq_number != '0) && in_data.direction_in
					&& (in_data.transfer_length != '0);
			end
			CMD_UNLINK_REQ: begin
				needs_scan = (in_data.seq_number != '0) && (in_data.unlink_target != '0);
				acc_key    = in_data.unlink_target;
			end
			CMD_SUBMIT_RSP, CMD_UNLINK_RSP: begin
				needs_scan = (in_data.seq_number != '0);
			end
			default: begin
				needs_scan = 1'b0;
			end
		endcase
		needs_scan = needs_scan && client_mode_q;
	end

	// result and write-back of the finishing transaction
	always_comb begin
		wr_en       = 1'b0;
		wr_addr     = scan_addr_q;
		wr_entry    = '0;
		cnt_inc     = 1'b0;
		cnt_dec     = 1'b0;
		res_restore = 1'b0;
		res_action  = ACT_NONE;
		res_status  = STS_OK;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (fire && client_mode_q) begin
			unique case (item_q.command)
				CMD_SUBMIT_REQ: begin
					if (work_q) begin
						if (key_hit_q) begin
							res_status = STS_DUPLICATE;
						end else if (!free_hit_q) begin
							res_status = STS_FULL;
						end else begin
							wr_en          = 1'b1;
							wr_addr        = free_idx_q;
							wr_entry.valid = 1'b1;
							wr_entry.key   = item_q.seq_number;
							cnt_inc        = 1'b1;
							res_action     = ACT_INSERTED;
						end
					end
				end
				CMD_UNLINK_REQ: begin
					if (work_q && key_hit_q) begin
						wr_en          = 1'b1;
						wr_addr        = key_idx_q;
						wr_entry.valid = 1'b1;
						wr_entry.key   = item_q.unlink_target;
						wr_entry.tag   = item_q.seq_number;
						res_action     = ACT_TAGGED;
					end
				end
				CMD_SUBMIT_RSP: begin
					if (work_q && key_hit_q) begin
						wr_en       = 1'b1;
						wr_addr     = key_idx_q;
						cnt_dec     = (count_q != '0);
						res_restore = 1'b1;
						res_action  = ACT_REMOVED;
					end
				end
				CMD_UNLINK_RSP: begin
					if (work_q && tag_hit_q) begin
						wr_en      = 1'b1;
						wr_addr    = tag_idx_q;
						cnt_dec    = (count_q != '0);
						res_action = ACT_REMOVED;
					end
				end
				default: begin
					res_status = STS_UNEXPECTED;
				end
			endcase
		end
	end

	always_comb begin
		count_next = count_q;
		if (cnt_inc) begin
			count_next = count_q + CW'(1);
		end else if (cnt_dec) begin
			count_next = count_q - CW'(1);
		end
		count_ext = {{PCOUNT_W{1'b0}}, count_next};
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_entry_s1 <= mem[scan_addr_q];
		rd_addr_s1  <= scan_addr_q;
	end

	// sequencer, scan bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			scan_addr_q  <= '0;
			issued_all_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			count_q      <= '0;
			work_q       <= 1'b0;
			key_hit_q    <= 1'b0;
			free_hit_q   <= 1'b0;
			tag_hit_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && !issued_all_q;
			if (out_valid_q && out_ready && !fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (scan_addr_q == LAST_IDX) begin
						scan_addr_q <= '0;
						state_q     <= ST_IDLE;
					end else begin
						scan_addr_q <= scan_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						item_q       <= in_data;
						srch_key_q   <= acc_key;
						work_q       <= needs_scan;
						key_hit_q    <= 1'b0;
						free_hit_q   <= 1'b0;
						tag_hit_q    <= 1'b0;
						scan_addr_q  <= '0;
						issued_all_q <= 1'b0;
						state_q      <= needs_scan ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					// issue one read per cycle
					if (!issued_all_q) begin
						if (scan_addr_q == LAST_IDX) begin
							issued_all_q <= 1'b1;
						end else begin
							scan_addr_q <= scan_addr_q + AW'(1);
						end
					end
					// compare the row read in the previous cycle
					if (rd_vld_s1) begin
						if (rd_entry_s1.valid) begin
							if (!key_hit_q && rd_entry_s1.key == srch_key_q) begin
								key_hit_q <= 1'b1;
								key_idx_q <= rd_addr_s1;
							end
							if (rd_entry_s1.tag != '0 && rd_entry_s1.tag == item_q.seq_number
								&& (!tag_hit_q || rd_entry_s1.key < tag_key_q)) begin
								tag_hit_q <= 1'b1;
								tag_idx_q <= rd_addr_s1;
								tag_key_q <= rd_entry_s1.key;
							end
						end else if (!free_hit_q) begin
							free_hit_q <= 1'b1;
							free_idx_q <= rd_addr_s1;
						end
						if (rd_addr_s1 == LAST_IDX) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fire) begin
						count_q                <= count_next;
						out_q.restore_dir_in   <= res_restore;
						out_q.action           <= res_action;
						out_q.status           <= res_status;
						out_q.pending_count    <= count_ext[PCOUNT_W-1:0];
						out_valid_q            <= 1'b1;
						scan_addr_q            <= '0;
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sim/pending_in_request_tracker_tb.sv]
`timescale 1ns / 1ps

module pending_in_request_tracker_tb;
	import pirt_pkg::*;

	localparam int ROWS = 64;
	localparam int IDLE_LIMIT = 5000;
	localparam logic [2:0] CMD_OTHER = 3'd4;

	// kinds of header the random generator produces
	typedef enum {
		K_INSERT, K_DUP, K_BAD_SUBMIT, K_SUBMIT_RSP, K_STRAY_RSP,
		K_TAG, K_STRAY_TAG, K_UNLINK_RSP, K_OTHER, K_JUNK
	} kind_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_wr_en = 1'b0;
	logic      cfg_wr_data = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// headers waiting to be sent and results waiting to arrive
	in_item_t  pending_q[$];
	out_item_t expected_q[$];

	// tracker image: client mode and table rows
	logic             mode_model = 1'b1;
	logic             row_live[ROWS];
	logic [SEQ_W-1:0] row_key[ROWS];
	logic [SEQ_W-1:0] row_tag[ROWS];
	int unsigned      row_count = 0;

	// generator's view of what should be in the table
	logic [SEQ_W-1:0] live_key[$];
	logic [SEQ_W-1:0] live_tag[$];
	logic [SEQ_W-1:0] next_seq;

	int headers_queued = 0;
	int results_checked = 0;
	int errors = 0;
	int mode_writes = 0;
	int n_inserted = 0, n_tagged = 0, n_removed = 0;
	int n_full = 0, n_dup = 0, n_unexpected = 0;

	int send_gap = 0, send_calm = 0;
	int recv_hold = 0, recv_calm = 0;
	int idle_cycles = 0;
	out_item_t want;

	pending_in_request_tracker #(.TABLE_ENTRIES(ROWS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// first live row holding this key, or -1
	function automatic int lookup_key(input logic [SEQ_W-1:0] key);
		for (int i = 0; i < ROWS; i++)
			if (row_live[i] && row_key[i] == key) return i;
		return -1;
	endfunction

	function automatic void drop_row(input int i);
		row_live[i] = 1'b0;
		if (row_count > 0) row_count--;
		n_removed++;
	endfunction

	// apply one header to the table image and return its result
	function automatic out_item_t track_header(input in_item_t h);
		out_item_t r;
		int hit;
		int slot;
		r = '0;
		if (mode_model) begin
			case (h.command)
			CMD_SUBMIT_REQ: begin
				if (h.seq_number != '0 && h.direction_in && h.transfer_length != '0) begin
					slot = -1;
					for (int i = 0; i < ROWS; i++)
						if (!row_live[i] && slot < 0) slot = i;
					if (lookup_key(h.seq_number) >= 0) begin
						r.status = STS_DUPLICATE;
						n_dup++;
					end else if (slot < 0) begin
						r.status = STS_FULL;
						n_full++;
					end else begin
						row_live[slot] = 1'b1;
						row_key[slot] = h.seq_number;
						row_tag[slot] = '0;
						row_count++;
						r.action = ACT_INSERTED;
						n_inserted++;
					end
				end
			end
			CMD_UNLINK_REQ: begin
				if (h.seq_number != '0 && h.unlink_target != '0) begin
					hit = lookup_key(h.unlink_target);
					if (hit >= 0) begin
						row_tag[hit] = h.seq_number;
						r.action = ACT_TAGGED;
						n_tagged++;
					end
				end
			end
			CMD_SUBMIT_RSP: begin
				if (h.seq_number != '0) begin
					hit = lookup_key(h.seq_number);
					if (hit >= 0) begin
						drop_row(hit);
						r.restore_dir_in = 1'b1;
						r.action = ACT_REMOVED;
					end
				end
			end
			CMD_UNLINK_RSP: begin
				// several rows may carry the tag: the smallest key goes
				if (h.seq_number != '0) begin
					hit = -1;
					for (int i = 0; i < ROWS; i++)
						if (row_live[i] && row_tag[i] != '0 && row_tag[i] == h.seq_number
							&& (hit < 0 || row_key[i] < row_key[hit])) hit = i;
					if (hit >= 0) begin
						drop_row(hit);
						r.action = ACT_REMOVED;
					end
				end
			end
			default: begin
				r.status = STS_UNEXPECTED;
				n_unexpected++;
			end
			endcase
		end
		r.pending_count = PCOUNT_W'(row_count);
		return r;
	endfunction

	// mostly short pauses, a few long ones
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	function automatic logic [SEQ_W-1:0] fresh_seq();
		logic [SEQ_W-1:0] s;
		next_seq = next_seq + 1'b1;
		s = ($urandom_range(0, 3) == 0) ? SEQ_W'($urandom) : next_seq;
		if (s == '0) s = SEQ_W'(1);
		return s;
	endfunction

	function automatic logic [LEN_W-1:0] rand_len();
		logic [LEN_W-1:0] len;
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) len = LEN_W'($urandom_range(1, 4096));
		else if (r < 9) len = LEN_W'($urandom);
		else len = '1;
		if (len == '0) len = LEN_W'(1);
		return len;
	endfunction

	task automatic push_header(input logic [2:0] cmd, input logic [SEQ_W-1:0] seq,
		input logic dir, input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] target);
		in_item_t h;
		h.command = cmd;
		h.seq_number = seq;
		h.direction_in = dir;
		h.transfer_length = len;
		h.unlink_target = target;
		pending_q.push_back(h);
		headers_queued++;
	endtask

	// field extremes and each corner of the command handling
	task automatic queue_directed();
		push_header(CMD_SUBMIT_REQ, 32'hFFFF_FFFF, 1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		push_header(CMD_SUBMIT_REQ, 32'd1, 1'b1, 31'd1, 32'd0);
		push_header(CMD_SUBMIT_REQ, 32'd1, 1'b1, 31'd5, 32'd0);
		push_header(CMD_SUBMIT_REQ, 32'd5, 1'b0, 31'd10, 32'd0);
		push_header(CMD_SUBMIT_REQ, 32'd6, 1'b1, 31'd0, 32'd0);
		push_header(CMD_SUBMIT_REQ, 32'd0, 1'b1, 31'd5, 32'd0);
		push_header(CMD_UNLINK_REQ, 32'd100, 1'b0, 31'd0, 32'd1);
		push_header(CMD_UNLINK_REQ, 32'd101, 1'b0, 31'd0, 32'd1);
		push_header(CMD_UNLINK_REQ, 32'd102, 1'b0, 31'd0, 32'd0);
		push_header(CMD_UNLINK_REQ, 32'd0, 1'b0, 31'd0, 32'hFFFF_FFFF);
		push_header(CMD_UNLINK_REQ, 32'd103, 1'b0, 31'd0, 32'd12345);
		push_header(CMD_UNLINK_REQ, 32'd101, 1'b1, 31'd0, 32'hFFFF_FFFF);
		// shared tag: key 1 in the higher row leaves first
		push_header(CMD_UNLINK_RSP, 32'd101, 1'b0, 31'd0, 32'd0);
		push_header(CMD_UNLINK_RSP, 32'd101, 1'b0, 31'd0, 32'd0);
		push_header(CMD_UNLINK_RSP, 32'd0, 1'b0, 31'd0, 32'd0);
		push_header(CMD_SUBMIT_RSP, 32'd0, 1'b0, 31'd0, 32'd0);
		push_header(CMD_SUBMIT_REQ, 32'd7, 1'b1, 31'd64, 32'd0);
		push_header(CMD_SUBMIT_RSP, 32'd7, 1'b0, 31'd0, 32'd0);
		push_header(CMD_SUBMIT_RSP, 32'd7, 1'b0, 31'd0, 32'd0);
		push_header(CMD_UNLINK_RSP, 32'd100, 1'b0, 31'd0, 32'd0);
		for (int k = 0; k < 4; k++) begin
			if (k[0]) push_header(3'(CMD_OTHER + k), '1, 1'b1, '1, '1);
			else push_header(3'(CMD_OTHER + k), '0, 1'b0, '0, '0);
		end
	endtask

	// random headers; with track set the generator follows the table
	task automatic queue_random(input int count, input int ins_pct, input int ret_pct,
		input bit track);
		in_item_t h;
		kind_t kind;
		int pick;
		int idx;
		int tag_rows[$];
		logic [SEQ_W-1:0] tag_val;
		for (int n = 0; n < count; n++) begin
			h.command = CMD_SUBMIT_REQ;
			h.seq_number = fresh_seq();
			h.direction_in = 1'b1;
			h.transfer_length = rand_len();
			h.unlink_target = SEQ_W'($urandom);
			tag_rows.delete();
			foreach (live_tag[i])
				if (live_tag[i] != '0) tag_rows.push_back(i);

			pick = $urandom_range(0, 99);
			if (pick < ins_pct) begin
				kind = K_INSERT;
			end else if (pick < ins_pct + ret_pct) begin
				case ($urandom_range(0, 3))
				0, 1: kind = K_SUBMIT_RSP;
				2: kind = K_TAG;
				default: kind = K_UNLINK_RSP;
				endcase
			end else begin
				case ($urandom_range(0, 9))
				0: kind = K_DUP;
				1: kind = K_BAD_SUBMIT;
				2: kind = K_OTHER;
				3: kind = K_JUNK;
				4: kind = K_STRAY_RSP;
				5: kind = K_STRAY_TAG;
				default: kind = K_TAG;
				endcase
			end
			if (live_key.size() == 0 && (kind == K_DUP || kind == K_SUBMIT_RSP || kind == K_TAG))
				kind = K_STRAY_RSP;
			if (kind == K_UNLINK_RSP && tag_rows.size() == 0) kind = K_STRAY_RSP;
			idx = (live_key.size() > 0) ? $urandom_range(0, live_key.size() - 1) : 0;

			case (kind)
			K_INSERT: begin
				if (track && live_key.size() < ROWS) begin
					live_key.push_back(h.seq_number);
					live_tag.push_back('0);
				end
			end
			K_DUP: h.seq_number = live_key[idx];
			K_BAD_SUBMIT: begin
				h.direction_in = 1'($urandom_range(0, 1));
				h.transfer_length = ($urandom_range(0, 1) != 0) ? '0 : LEN_W'($urandom);
				if ($urandom_range(0, 1) != 0) h.seq_number = '0;
				case ($urandom_range(0, 2))
				0: h.direction_in = 1'b0;
				1: h.transfer_length = '0;
				default: h.seq_number = '0;
				endcase
			end
			K_SUBMIT_RSP: begin
				h.command = CMD_SUBMIT_RSP;
				h.seq_number = live_key[idx];
				h.direction_in = 1'($urandom_range(0, 1));
				if (track) begin
					live_key.delete(idx);
					live_tag.delete(idx);
				end
			end
			K_STRAY_RSP: begin
				h.command = ($urandom_range(0, 1) != 0) ? CMD_SUBMIT_RSP : CMD_UNLINK_RSP;
				if ($urandom_range(0, 2) == 0) h.seq_number = '0;
			end
			K_TAG: begin
				h.command = CMD_UNLINK_REQ;
				h.unlink_target = live_key[idx];
				if (tag_rows.size() > 0 && $urandom_range(0, 3) == 0)
					h.seq_number = live_tag[tag_rows[$urandom_range(0, tag_rows.size() - 1)]];
				if (track) live_tag[idx] = h.seq_number;
			end
			K_STRAY_TAG: begin
				h.command = CMD_UNLINK_REQ;
				if ($urandom_range(0, 2) == 0) h.seq_number = '0;
				if ($urandom_range(0, 1) != 0) h.unlink_target = '0;
			end
			K_UNLINK_RSP: begin
				// the smallest key carrying the tag is the one released
				tag_val = live_tag[tag_rows[$urandom_range(0, tag_rows.size() - 1)]];
				h.command = CMD_UNLINK_RSP;
				h.seq_number = tag_val;
				idx = -1;
				foreach (live_tag[i])
					if (live_tag[i] == tag_val && (idx < 0 || live_key[i] < live_key[idx]))
						idx = i;
				if (track) begin
					live_key.delete(idx);
					live_tag.delete(idx);
				end
			end
			K_OTHER: begin
				h.command = 3'(CMD_OTHER + $urandom_range(0, 3));
				h.seq_number = SEQ_W'($urandom);
				h.direction_in = 1'($urandom_range(0, 1));
				h.transfer_length = LEN_W'($urandom);
			end
			default: begin
				h.command = 3'($urandom_range(0, 7));
				h.seq_number = SEQ_W'($urandom);
				h.direction_in = 1'($urandom_range(0, 1));
				h.transfer_length = LEN_W'($urandom);
			end
			endcase
			pending_q.push_back(h);
			headers_queued++;
		end
	endtask

	// every queued header has had its result back
	task automatic wait_idle();
		do @(posedge clk);
		while (results_checked != headers_queued);
	endtask

	task automatic set_mode(input logic value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_model = value;
		mode_writes++;
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$display("%t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// sender: one header per transaction, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) expected_q.push_back(track_header(in_data));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					in_data <= pending_q.pop_front();
					in_valid <= 1'b1;
					if (send_calm > 0) send_calm--;
					else if ($urandom_range(0, 199) == 0) send_calm = $urandom_range(40, 200);
					send_gap = (send_calm > 0) ? 0 : pause_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: compare each result with the oldest expectation, random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%t: result %h with no header outstanding", $time, out_data);
					errors++;
				end else begin
					want = expected_q.pop_front();
					check_field("restore_dir_in", 8'(want.restore_dir_in),
						8'(out_data.restore_dir_in));
					check_field("action", 8'(want.action), 8'(out_data.action));
					check_field("status", 8'(want.status), 8'(out_data.status));
					check_field("pending_count", 8'(want.pending_count),
						8'(out_data.pending_count));
					results_checked++;
				end
			end
			if (recv_calm > 0) recv_calm--;
			else if ($urandom_range(0, 1999) == 0) recv_calm = $urandom_range(300, 1500);
			if (recv_hold > 0) begin
				recv_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (recv_calm == 0 && $urandom_range(0, 7) == 0) recv_hold = pause_len();
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%t: no transaction for %0d cycles", $time, idle_cycles);
			$display("pending_in_request_tracker: mismatch");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	initial begin
		for (int i = 0; i < ROWS; i++) row_live[i] = 1'b0;
		next_seq = SEQ_W'($urandom);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		queue_directed();
		// fill until the table overflows
		queue_random(250, 75, 15, 1'b1);
		// server side passes everything, table stays as is
		set_mode(1'b0);
		queue_random(150, 40, 40, 1'b0);
		set_mode(1'b1);
		// drain, then a balanced mix
		queue_random(300, 15, 70, 1'b1);
		queue_random(500, 40, 40, 1'b1);
		set_mode(1'b0);
		queue_random(100, 40, 40, 1'b0);
		set_mode(1'b1);
		queue_random(300, 45, 35, 1'b1);

		wait_idle();
		repeat (ROWS + 8) @(posedge clk);
		$display("%0d headers over %0d mode writes: %0d inserts, %0d tags, %0d removals",
			headers_queued, mode_writes, n_inserted, n_tagged, n_removed);
		$display("%0d full-table drops, %0d duplicate inserts, %0d unknown commands",
			n_full, n_dup, n_unexpected);
		if (errors == 0)
			$display("pending_in_request_tracker: match");
		else
			$display("pending_in_request_tracker: mismatch");
		$finish;
	end

endmodule

[files.f]
rtl/pirt_pkg.sv
rtl/pending_in_request_tracker.sv
sim/pending_in_request_tracker_tb.sv
